/* rtl/core/pfc_pkg.sv */
`default_nettype none
package pfc_pkg;

    localparam int SIDE      = 5;
    localparam int SQ_SIZE   = 25;
    localparam int NUM_CODES = 26;

    localparam logic [4:0] CODE_J    = 5'd9;
    localparam logic [4:0] LAST_CODE = 5'd25;

    localparam logic [1:0] CMD_KEY = 2'd0;
    localparam logic [1:0] CMD_ENC = 2'd1;
    localparam logic [1:0] CMD_DEC = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_READY = 2'd1;
    localparam logic [1:0] STAT_NO_LETTER = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_PLACE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
    } t_pos;

    function automatic t_pos f_split(input logic [4:0] p);
        t_pos q;
        logic [4:0] pc;
        pc = (p >= 5'(SQ_SIZE)) ? 5'd0 : p;
        if (pc >= 5'd20) begin
            q.row = 3'd4;
            q.col = 3'(pc - 5'd20);
        end else if (pc >= 5'd15) begin
            q.row = 3'd3;
            q.col = 3'(pc - 5'd15);
        end else if (pc >= 5'd10) begin
            q.row = 3'd2;
            q.col = 3'(pc - 5'd10);
        end else if (pc >= 5'd5) begin
            q.row = 3'd1;
            q.col = 3'(pc - 5'd5);
        end else begin
            q.row = 3'd0;
            q.col = 3'(pc);
        end
        return q;
    endfunction

    function automatic logic [4:0] f_join(input logic [2:0] row, input logic [2:0] col);
        logic [5:0] s;
        s = {1'b0, row, 2'b00} + {3'b000, row} + {3'b000, col};
        return s[4:0];
    endfunction

    function automatic logic [2:0] f_shift(input logic [2:0] x, input logic dec);
        logic [2:0] y;
        if (dec) begin
            y = (x == 3'd0) ? 3'd4 : x - 3'd1;
        end else begin
            y = (x == 3'd4) ? 3'd0 : x + 3'd1;
        end
        return y;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/pfc_ram.sv */
`default_nettype none
module pfc_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 32
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire                      i_re_a,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  wire                      i_re_b,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re_a) begin
            r_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule
`default_nettype wire

/* rtl/core/playfair_digraph_cipher_top.sv */
// Playfair cipher on a 5x5 key square, letters coded 0 (a) to 25 (z), j excluded.
// A word is taken at a rising edge where start is high and busy is low.
// Command key: the letter is appended to the square and no result is given.
// A key word marked last then walks all 26 letter codes, one per cycle,
// filling the square; busy stays high for the whole walk.
// A key word after a completed square begins a new key.
// Commands encipher and decipher: the letter place memory is read at the
// accepting edge, the key square memory in the PLACE state, and the result
// word stands on the outputs with o_valid high in the OUT state that follows.
// busy is low while the result is shown, so a new word can be taken then, but not during PLACE.
// A pair before the square is complete, or holding j or a code above 25, gives
// a result word with a non-zero status and zero letters. Command three is dropped.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset marks every letter unused and the square incomplete; the key square
// memory itself is not cleared, as its data is only used once fully written.
`default_nettype none
module playfair_digraph_cipher_top
    import pfc_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        start,
    output logic       busy,
    input  wire [1:0]  i_command,
    input  wire [4:0]  i_first_letter,
    input  wire [4:0]  i_second_letter,
    input  wire        i_last_item,
    output logic       o_valid,
    output logic [4:0] o_out_first,
    output logic [4:0] o_out_second,
    output logic [1:0] o_status,
    output logic       o_out_last
);

    t_state r_state, n_state;
    logic [NUM_CODES-1:0] r_valid, n_valid;
    logic [4:0] r_fill, n_fill;
    logic       r_ready, n_ready;
    logic [4:0] r_code, n_code;
    logic [1:0] r_status, n_status;
    logic       r_last, n_last;
    logic       r_dec, n_dec;

    logic       accept;
    logic       app_active;
    logic       app_clear;
    logic [4:0] app_code;
    logic       app_used;
    logic [4:0] app_fill;
    logic       app_write;
    logic       a_ok, b_ok;

    logic [4:0] lp_rdata_a, lp_rdata_b;
    logic [4:0] ks_rdata_a, ks_rdata_b;
    logic [4:0] ks_addr_a, ks_addr_b;
    t_pos       pos_a, pos_b;

    assign accept = start && !busy;

    always_comb begin
        app_active = 1'b0;
        app_clear  = 1'b0;
        app_code   = r_code;
        if (r_state == ST_FILL) begin
            app_active = 1'b1;
        end else if (accept && i_command == CMD_KEY) begin
            app_active = 1'b1;
            app_clear  = r_ready;
            app_code   = i_first_letter;
        end
        app_used  = !app_clear && (app_code < 5'(NUM_CODES)) && r_valid[app_code];
        app_fill  = app_clear ? 5'd0 : r_fill;
        app_write = app_active && (app_code < 5'(NUM_CODES)) && (app_code != CODE_J)
                    && !app_used && (app_fill < 5'(SQ_SIZE));
    end

    always_comb begin
        a_ok = (i_first_letter < 5'(NUM_CODES)) && r_valid[i_first_letter];
        b_ok = (i_second_letter < 5'(NUM_CODES)) && r_valid[i_second_letter];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE, ST_OUT: begin
                n_state = ST_IDLE;
                if (accept) begin
                    if (i_command == CMD_KEY) begin
                        n_state = i_last_item ? ST_FILL : ST_IDLE;
                    end else if (i_command == CMD_ENC || i_command == CMD_DEC) begin
                        n_state = ST_PLACE;
                    end
                end
            end
            ST_FILL: begin
                if (r_code == LAST_CODE) begin
                    n_state = ST_IDLE;
                end
            end
            ST_PLACE: begin
                n_state = ST_OUT;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_valid  = app_clear ? '0 : r_valid;
        n_fill   = app_fill;
        n_ready  = app_clear ? 1'b0 : r_ready;
        n_code   = r_code;
        n_status = r_status;
        n_last   = r_last;
        n_dec    = r_dec;
        if (app_write) begin
            n_valid[app_code] = 1'b1;
            n_fill = app_fill + 5'd1;
        end
        if (r_state == ST_FILL) begin
            n_code = r_code + 5'd1;
            if (r_code == LAST_CODE) begin
                n_ready = 1'b1;
            end
        end else begin
            n_code = 5'd0;
        end
        if (accept && (i_command == CMD_ENC || i_command == CMD_DEC)) begin
            n_last = i_last_item;
            n_dec  = (i_command == CMD_DEC);
            if (!r_ready) begin
                n_status = STAT_NOT_READY;
            end else if (!a_ok || !b_ok) begin
                n_status = STAT_NO_LETTER;
            end else begin
                n_status = STAT_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= '0;
            r_fill  <= 5'd0;
            r_ready <= 1'b0;
            r_code  <= 5'd0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_fill  <= n_fill;
            r_ready <= n_ready;
            r_code  <= n_code;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_last   <= n_last;
        r_dec    <= n_dec;
    end

    always_comb begin
        pos_a = f_split(lp_rdata_a);
        pos_b = f_split(lp_rdata_b);
        if (pos_a.row == pos_b.row) begin
            ks_addr_a = f_join(pos_a.row, f_shift(pos_a.col, r_dec));
            ks_addr_b = f_join(pos_b.row, f_shift(pos_b.col, r_dec));
        end else if (pos_a.col == pos_b.col) begin
            ks_addr_a = f_join(f_shift(pos_a.row, r_dec), pos_a.col);
            ks_addr_b = f_join(f_shift(pos_b.row, r_dec), pos_b.col);
        end else begin
            ks_addr_a = f_join(pos_a.row, pos_b.col);
            ks_addr_b = f_join(pos_b.row, pos_a.col);
        end
    end

    pfc_ram #(
        .WIDTH(5),
        .DEPTH(NUM_CODES)
    ) u_place_ram (
        .i_clk     (i_clk),
        .i_we      (app_write),
        .i_waddr   (app_code),
        .i_wdata   (app_fill),
        .i_re_a    (accept),
        .i_raddr_a (i_first_letter),
        .o_rdata_a (lp_rdata_a),
        .i_re_b    (accept),
        .i_raddr_b (i_second_letter),
        .o_rdata_b (lp_rdata_b)
    );

    pfc_ram #(
        .WIDTH(5),
        .DEPTH(SQ_SIZE)
    ) u_square_ram (
        .i_clk     (i_clk),
        .i_we      (app_write),
        .i_waddr   (app_fill),
        .i_wdata   (app_code),
        .i_re_a    (r_state == ST_PLACE),
        .i_raddr_a (ks_addr_a),
        .o_rdata_a (ks_rdata_a),
        .i_re_b    (r_state == ST_PLACE),
        .i_raddr_b (ks_addr_b),
        .o_rdata_b (ks_rdata_b)
    );

    always_comb begin
        busy         = (r_state == ST_FILL) || (r_state == ST_PLACE);
        o_valid      = (r_state == ST_OUT);
        o_status     = r_status;
        o_out_last   = r_last;
        o_out_first  = (r_status == STAT_OK) ? ks_rdata_a : 5'd0;
        o_out_second = (r_status == STAT_OK) ? ks_rdata_b : 5'd0;
    end

    a_busy_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(busy && o_valid))
        else $error("Result word shown while busy.");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 5'(SQ_SIZE))
        else $error("Fill count beyond the square.");

    a_place_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PLACE) |=> o_valid)
        else $error("Pair lookup gave no result word.");

    a_ok_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STAT_OK) |-> r_ready)
        else $error("Good status without a complete square.");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ready) |-> (r_fill == 5'(SQ_SIZE)))
        else $error("Square marked complete while not full.");

endmodule
`default_nettype wire
